[hdl/assert_macros.svh]
// assertion helpers for the allocator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds every cycle out of reset
`define CHK_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

// implication a |=> b
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[hdl/bfpa_pkg.sv]
package bfpa_pkg;

    localparam int LEN_BITS = 17;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] base_page;
        logic [16:0] page_count;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_page;
        logic [16:0] free_total;
    } rsp_beat_t;

    // saturating add of two lengths
    function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                    input logic [LEN_BITS-1:0] b);
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
    endfunction

endpackage

[hdl/bfpa_table.sv]
// extent table: start/length memory with one registered read port and valid flops
module bfpa_table #(
    parameter int DEPTH = 64,
    parameter int PW    = 16,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AW-1:0]                 rd_addr,
    output logic [PW-1:0]                 rd_start,
    output logic [bfpa_pkg::LEN_BITS-1:0] rd_len,
    output logic                          rd_valid,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [PW-1:0]                 wr_start,
    input  logic [bfpa_pkg::LEN_BITS-1:0] wr_len,
    input  logic                          set_en,
    input  logic [AW-1:0]                 set_addr,
    input  logic                          set_val
);
    logic [PW-1:0]                 start_mem [DEPTH];
    logic [bfpa_pkg::LEN_BITS-1:0] len_mem   [DEPTH];
    logic [DEPTH-1:0]              valid_reg;

    // payload memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr]   <= wr_len;
        end
        rd_start <= start_mem[rd_addr];
        rd_len   <= len_mem[rd_addr];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            if (set_en)
                valid_reg[set_addr] <= set_val;
            rd_valid <= valid_reg[rd_addr];
        end
    end
endmodule

[hdl/best_fit_page_allocator_top.sv]
// Best-fit page allocator. A command is taken when start is high and busy low; busy
// then stays high while a sequencer walks every table entry once through the single
// registered read port of the extent memory, one entry a cycle, and writes back.
// When the command is over, the result is shown for one cycle with done high; the
// receiver cannot stall and must take it.
module best_fit_page_allocator_top #(
    parameter int MAX_EXTENTS     = 64,
    parameter int PAGE_INDEX_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bfpa_pkg::cmd_beat_t cmd,
    output logic                done,
    output bfpa_pkg::rsp_beat_t rsp
);
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int PW = PAGE_INDEX_BITS;
    localparam int LB = bfpa_pkg::LEN_BITS;

    typedef enum logic [1:0] {IDLE, SCAN, WB} state_t;

    state_t          state_reg;
    logic [AW:0]     idx_reg;       // issued read address
    logic            rdv_reg;       // read data valid this cycle
    logic [AW-1:0]   ridx_reg;      // index of read data
    logic [1:0]      cmd_reg;
    logic [PW-1:0]   base_reg;
    logic [LB-1:0]   cnt_reg;
    logic [LB-1:0]   total_reg;
    logic            best_f_reg, bef_f_reg, aft_f_reg, emp_f_reg;
    logic [AW-1:0]   best_i_reg, bef_i_reg, aft_i_reg, emp_i_reg;
    logic [PW-1:0]   best_s_reg;
    logic [LB-1:0]   best_l_reg, bef_l_reg, aft_l_reg;
    logic [PW-1:0]   bef_s_reg;

    logic [PW-1:0]   rd_start;
    logic [LB-1:0]   rd_len;
    logic            rd_valid;
    logic            wr_en, set_en, set_val;
    logic [AW-1:0]   wr_addr, set_addr;
    logic [PW-1:0]   wr_start;
    logic [LB-1:0]   wr_len;

    bfpa_table #(.DEPTH(MAX_EXTENTS), .PW(PW), .AW(AW)) u_table (
        .clk(clk), .rst_n(rst_n), .rd_addr(idx_reg[AW-1:0]),
        .rd_start(rd_start), .rd_len(rd_len), .rd_valid(rd_valid),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_start(wr_start), .wr_len(wr_len),
        .set_en(set_en), .set_addr(set_addr), .set_val(set_val)
    );

    // base page at table width
    logic [PW-1:0] base_w;
    assign base_w = base_reg;
    // extent end, compared wide to avoid wrap
    logic [LB+PW:0] rd_end_full, base_full, end_full;
    assign rd_end_full = (LB + PW + 1)'(rd_start) + (LB + PW + 1)'(rd_len);
    assign base_full   = (LB + PW + 1)'(base_reg);
    assign end_full    = (LB + PW + 1)'(base_reg) + (LB + PW + 1)'(cnt_reg);

    // write-back decision
    logic [1:0]    st_w;
    logic [PW-1:0] gr_w;
    logic [LB-1:0] tot_w;
    always_comb
    begin
        wr_en = 1'b0; set_en = 1'b0; set_val = 1'b0;
        wr_addr = emp_i_reg; set_addr = emp_i_reg;
        wr_start = base_w; wr_len = cnt_reg;
        st_w = bfpa_pkg::ST_OK; gr_w = '0; tot_w = total_reg;
        if (state_reg == WB && cnt_reg != '0)
        begin
            case (cmd_reg)
                bfpa_pkg::CMD_ADD:
                begin
                    if (!emp_f_reg)
                        st_w = bfpa_pkg::ST_FULL;
                    else
                    begin
                        wr_en = 1'b1; set_en = 1'b1; set_val = 1'b1;
                        tot_w = bfpa_pkg::sat_add(total_reg, cnt_reg);
                    end
                end
                bfpa_pkg::CMD_ALLOC:
                begin
                    if (!best_f_reg || cnt_reg > total_reg)
                        st_w = bfpa_pkg::ST_NO_FIT;
                    else
                    begin
                        gr_w = best_s_reg;
                        wr_addr = best_i_reg; set_addr = best_i_reg;
                        wr_start = best_s_reg + PW'(cnt_reg);
                        wr_len = best_l_reg - cnt_reg;
                        if (best_l_reg > cnt_reg)
                            wr_en = 1'b1;
                        else
                            set_en = 1'b1;
                        tot_w = total_reg - cnt_reg;
                    end
                end
                bfpa_pkg::CMD_FREE:
                begin
                    tot_w = bfpa_pkg::sat_add(total_reg, cnt_reg);
                    if (bef_f_reg && aft_f_reg && bef_i_reg != aft_i_reg)
                    begin
                        wr_en = 1'b1; wr_addr = bef_i_reg; wr_start = bef_s_reg;
                        wr_len = bfpa_pkg::sat_add(bfpa_pkg::sat_add(bef_l_reg, cnt_reg),
                                                   aft_l_reg);
                        set_en = 1'b1; set_addr = aft_i_reg;
                    end
                    else if (bef_f_reg)
                    begin
                        wr_en = 1'b1; wr_addr = bef_i_reg; wr_start = bef_s_reg;
                        wr_len = bfpa_pkg::sat_add(bef_l_reg, cnt_reg);
                    end
                    else if (aft_f_reg)
                    begin
                        wr_en = 1'b1; wr_addr = aft_i_reg; wr_start = base_w;
                        wr_len = bfpa_pkg::sat_add(aft_l_reg, cnt_reg);
                    end
                    else if (emp_f_reg)
                    begin
                        wr_en = 1'b1; set_en = 1'b1; set_val = 1'b1;
                    end
                    else
                    begin
                        st_w = bfpa_pkg::ST_FULL;
                        tot_w = total_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != IDLE);

    // sequencer, scan compare unit and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE; idx_reg <= '0; rdv_reg <= 1'b0; ridx_reg <= '0;
            total_reg <= '0; done <= 1'b0; rsp <= '0;
            cmd_reg <= '0; base_reg <= '0; cnt_reg <= '0;
            best_f_reg <= 1'b0; bef_f_reg <= 1'b0; aft_f_reg <= 1'b0; emp_f_reg <= 1'b0;
            best_i_reg <= '0; bef_i_reg <= '0; aft_i_reg <= '0; emp_i_reg <= '0;
            best_s_reg <= '0; bef_s_reg <= '0;
            best_l_reg <= '0; bef_l_reg <= '0; aft_l_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg <= cmd.command;
                        base_reg <= PW'(cmd.base_page);
                        cnt_reg <= cmd.page_count;
                        idx_reg <= '0; rdv_reg <= 1'b0;
                        best_f_reg <= 1'b0; bef_f_reg <= 1'b0;
                        aft_f_reg <= 1'b0; emp_f_reg <= 1'b0;
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    rdv_reg <= (idx_reg < (AW + 1)'(MAX_EXTENTS));
                    ridx_reg <= idx_reg[AW-1:0];
                    if (idx_reg < (AW + 1)'(MAX_EXTENTS))
                        idx_reg <= idx_reg + 1'b1;
                    if (rdv_reg)
                    begin
                        if (!rd_valid)
                        begin
                            if (!emp_f_reg)
                            begin
                                emp_f_reg <= 1'b1; emp_i_reg <= ridx_reg;
                            end
                        end
                        else
                        begin
                            if (rd_len >= cnt_reg && (!best_f_reg || rd_len < best_l_reg ||
                                (rd_len == best_l_reg && rd_start < best_s_reg)))
                            begin
                                best_f_reg <= 1'b1; best_i_reg <= ridx_reg;
                                best_s_reg <= rd_start; best_l_reg <= rd_len;
                            end
                            if (!bef_f_reg && rd_end_full == base_full)
                            begin
                                bef_f_reg <= 1'b1; bef_i_reg <= ridx_reg;
                                bef_s_reg <= rd_start; bef_l_reg <= rd_len;
                            end
                            if (!aft_f_reg && (LB + PW + 1)'(rd_start) == end_full)
                            begin
                                aft_f_reg <= 1'b1; aft_i_reg <= ridx_reg;
                                aft_l_reg <= rd_len;
                            end
                        end
                    end
                    else if (idx_reg == (AW + 1)'(MAX_EXTENTS))
                        state_reg <= WB;
                end
                WB:
                begin
                    total_reg <= tot_w;
                    rsp.status <= st_w;
                    rsp.granted_page <= 16'(gr_w);
                    rsp.free_total <= tot_w;
                    done <= 1'b1;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

[hdl/bfpa_checker.sv]
`include "assert_macros.svh"
// port-level checks on the allocator
module bfpa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input bfpa_pkg::rsp_beat_t rsp
);
    // accepted command raises busy
    `CHK_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)
    // a result beat is shown only once the command is over
    `CHK_ALWAYS(a_idle_at_done, clk, rst_n, !done || !busy)
    // result beats are single cycles
    `CHK_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // only allocate grants a page, so a refusal grants none
    `CHK_ALWAYS(a_refusal_no_grant, clk, rst_n, !done || rsp.status == bfpa_pkg::ST_OK || rsp.granted_page == '0)
endmodule

bind best_fit_page_allocator_top bfpa_checker u_bfpa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
